@@ rtl/periodic_oneshot_timer_table_defines.svh @@
// ----------------------------------------------------------------------------
// Periodic / one-shot timer table: assertion macros
// Shared property forms for the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer table package
// Command, kind and event codes plus the command record passed front to back.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_CREATE  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned SLOT_W = 6;

  typedef enum logic [1:0] {
    KIND_UNUSED   = 2'd0,
    KIND_PERIODIC = 2'd1,
    KIND_ONESHOT  = 2'd2,
    KIND_PAUSED   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EV_EXPIRED = 2'd0,
    EV_CREATED = 2'd1,
    EV_FULL    = 2'd2
  } ev_kind_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CREATE,
    OP_RESTART
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [1:0]        kind;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

@@ rtl/periodic_oneshot_timer_table.sv @@
// ----------------------------------------------------------------------------
// Periodic / one-shot timer table
// Slot table of software-style timers driven by tick, create and restart.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i, timer_kind_i, tick_count_i and slot_index_i and raise
// start; the command beat is taken on any edge where start is high and busy
// is low. A two-entry command queue sits in front of the slot engine, so busy
// rises only when two commands are waiting behind the one being run.
// Results come out as single-cycle beats marked by event_valid_o, with
// event_kind_o, event_slot_o and last_event_o alongside. The receiver has no
// way to hold them off and must take every beat as it comes.
// The engine takes a command from the queue in an idle cycle, the cycle after
// the accepting edge when it is free. A tick holds the engine while it walks
// the slots one per cycle through a read/update pipeline on the counter
// store. Each expiry beat is held back until the next slot fires or the walk
// ends, and the last one, carrying last_event_o, comes in the cycle after the
// tick leaves the engine. A create scans the slot kinds one per cycle,
// stopping at an unused slot or the table end, and gives its single result
// in the cycle after the slot is found or the scan ends. A restart is done
// in the idle cycle that takes it and gives no result.
// Reset marks every slot unused and empties the queue; no clearing pass runs.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_table #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd_i,
  input  logic [1:0]                 timer_kind_i,
  input  logic [ptt_pkg::CNT_W-1:0]  tick_count_i,
  input  logic [ptt_pkg::SLOT_W-1:0] slot_index_i,
  output logic                       event_valid_o,
  output logic [1:0]                 event_kind_o,
  output logic [ptt_pkg::SLOT_W-1:0] event_slot_o,
  output logic                       last_event_o
);
  import ptt_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  ptt_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .timer_kind_i (timer_kind_i),
    .tick_count_i (tick_count_i),
    .slot_index_i (slot_index_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  ptt_engine #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .event_valid_o (event_valid_o),
    .event_kind_o  (event_kind_o),
    .event_slot_o  (event_slot_o),
    .last_event_o  (last_event_o)
  );

endmodule

@@ rtl/ptt_front.sv @@
// ----------------------------------------------------------------------------
// Timer table front end
// Accepts command beats, drops those that do nothing, and queues the rest.
// ----------------------------------------------------------------------------
module ptt_front #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd_i,
  input  logic [1:0]                 timer_kind_i,
  input  logic [ptt_pkg::CNT_W-1:0]  tick_count_i,
  input  logic [ptt_pkg::SLOT_W-1:0] slot_index_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output ptt_pkg::cmd_t              cmd_o
);
  import ptt_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       keep, push, pop;
  cmd_t       cls;

  // Restarts of slots past the table and unknown commands never reach the back.
  always_comb begin
    cls.kind  = timer_kind_i;
    cls.count = tick_count_i;
    cls.slot  = slot_index_i;
    cls.op    = OP_TICK;
    keep      = 1'b0;
    unique case (cmd_i)
      CMD_TICK: begin
        cls.op = OP_TICK;
        keep   = 1'b1;
      end
      CMD_CREATE: begin
        cls.op = OP_CREATE;
        keep   = 1'b1;
      end
      CMD_RESTART: begin
        cls.op = OP_RESTART;
        keep   = ({1'b0, slot_index_i} < 7'(NUM_SLOTS));
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy        = (fill_q == 2'd2);
  assign push        = start && !busy && keep;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= cls;
  end

endmodule

@@ rtl/ptt_engine.sv @@
// ----------------------------------------------------------------------------
// Timer table engine
// Runs queued commands against the slot table, one slot per cycle.
// ----------------------------------------------------------------------------
module ptt_engine #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  ptt_pkg::cmd_t              cmd_i,
  output logic                       event_valid_o,
  output logic [1:0]                 event_kind_o,
  output logic [ptt_pkg::SLOT_W-1:0] event_slot_o,
  output logic                       last_event_o
);
  import ptt_pkg::*;
  `include "periodic_oneshot_timer_table_defines.svh"

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] NumSlotsC = CW'(NUM_SLOTS);

  state_e state_q, state_d;

  // Slot kinds live in flops so reset marks every slot unused.
  logic [1:0]       kind_q [NUM_SLOTS];
  logic [CNT_W-1:0] cnt_mem [NUM_SLOTS];
  logic [CNT_W-1:0] rld_mem [NUM_SLOTS];
  logic [CNT_W-1:0] rd_cnt_q, rd_rld_q;

  logic [CW-1:0]    idx_q, idx_d;
  logic             proc_vld_q, proc_vld_d;
  logic [AW-1:0]    proc_idx_q, proc_idx_d;
  logic             pend_vld_q, pend_vld_d;
  logic [AW-1:0]    pend_slot_q, pend_slot_d;
  logic [1:0]       new_kind_q, new_kind_d;
  logic [CNT_W-1:0] new_cnt_q, new_cnt_d;

  logic             ev_vld_q, ev_vld_d;
  ev_kind_e         ev_kind_q, ev_kind_d;
  logic [AW-1:0]    ev_slot_q, ev_slot_d;
  logic             ev_last_q, ev_last_d;

  logic             kind_we;
  logic [AW-1:0]    kind_waddr;
  logic [1:0]       kind_wdata;
  logic             cnt_we, rld_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [AW-1:0]    mem_raddr;

  logic [1:0]       proc_kind;
  logic             fire;
  logic             issue_done;
  logic [1:0]       scan_kind;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign mem_raddr   = idx_q[AW-1:0];
  assign proc_kind   = kind_q[proc_idx_q];
  assign scan_kind   = kind_q[idx_q[AW-1:0]];
  assign issue_done  = (idx_q == NumSlotsC);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_TICK:    state_d = ST_TICK;
            OP_CREATE:  state_d = ST_SCAN;
            OP_RESTART: state_d = ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: if (issue_done && !proc_vld_q) state_d = ST_IDLE;
      ST_SCAN: begin
        if (issue_done || (scan_kind == KIND_UNUSED)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    idx_d       = idx_q;
    proc_vld_d  = 1'b0;
    proc_idx_d  = proc_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    new_kind_d  = new_kind_q;
    new_cnt_d   = new_cnt_q;
    ev_vld_d    = 1'b0;
    ev_kind_d   = EV_EXPIRED;
    ev_slot_d   = '0;
    ev_last_d   = 1'b0;
    kind_we     = 1'b0;
    kind_waddr  = '0;
    kind_wdata  = KIND_UNUSED;
    cnt_we      = 1'b0;
    rld_we      = 1'b0;
    mem_waddr   = '0;
    cnt_wdata   = '0;
    fire        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        idx_d      = '0;
        pend_vld_d = 1'b0;
        new_kind_d = cmd_i.kind;
        new_cnt_d  = cmd_i.count;
        if (cmd_valid_i && (cmd_i.op == OP_RESTART)) begin
          kind_we    = 1'b1;
          kind_waddr = cmd_i.slot[AW-1:0];
          kind_wdata = KIND_ONESHOT;
          cnt_we     = 1'b1;
          mem_waddr  = cmd_i.slot[AW-1:0];
          cnt_wdata  = cmd_i.count;
        end
      end

      ST_TICK: begin
        // Issue stage reads slot idx_q while the process stage updates the one before.
        if (!issue_done) begin
          idx_d      = idx_q + CW'(1);
          proc_vld_d = 1'b1;
          proc_idx_d = idx_q[AW-1:0];
        end
        if (proc_vld_q) begin
          mem_waddr = proc_idx_q;
          if (proc_kind == KIND_PERIODIC) begin
            fire      = (rd_cnt_q == '0);
            cnt_we    = 1'b1;
            cnt_wdata = (fire ? rd_rld_q : rd_cnt_q) - CNT_W'(1);
          end else if (proc_kind == KIND_ONESHOT) begin
            fire      = (rd_cnt_q == CNT_W'(1));
            cnt_we    = 1'b1;
            cnt_wdata = rd_cnt_q - CNT_W'(rd_cnt_q != '0);
          end
          // A fire is held until the next fire or the walk ends, so the run's final beat can carry last.
          if (fire) begin
            pend_vld_d  = 1'b1;
            pend_slot_d = proc_idx_q;
            if (pend_vld_q) begin
              ev_vld_d  = 1'b1;
              ev_kind_d = EV_EXPIRED;
              ev_slot_d = pend_slot_q;
            end
          end
        end else if (issue_done && pend_vld_q) begin
          ev_vld_d   = 1'b1;
          ev_kind_d  = EV_EXPIRED;
          ev_slot_d  = pend_slot_q;
          ev_last_d  = 1'b1;
          pend_vld_d = 1'b0;
        end
      end

      ST_SCAN: begin
        if (issue_done) begin
          ev_vld_d  = 1'b1;
          ev_kind_d = EV_FULL;
          ev_last_d = 1'b1;
        end else if (scan_kind == KIND_UNUSED) begin
          kind_we    = 1'b1;
          kind_waddr = idx_q[AW-1:0];
          kind_wdata = new_kind_q;
          cnt_we     = 1'b1;
          rld_we     = 1'b1;
          mem_waddr  = idx_q[AW-1:0];
          cnt_wdata  = new_cnt_q;
          ev_vld_d   = 1'b1;
          ev_kind_d  = EV_CREATED;
          ev_slot_d  = idx_q[AW-1:0];
          ev_last_d  = 1'b1;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      proc_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      ev_vld_q   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) kind_q[i] <= KIND_UNUSED;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      proc_vld_q <= proc_vld_d;
      pend_vld_q <= pend_vld_d;
      ev_vld_q   <= ev_vld_d;
      if (kind_we) kind_q[kind_waddr] <= kind_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q  <= proc_idx_d;
    pend_slot_q <= pend_slot_d;
    new_kind_q  <= new_kind_d;
    new_cnt_q   <= new_cnt_d;
    ev_kind_q   <= ev_kind_d;
    ev_slot_q   <= ev_slot_d;
    ev_last_q   <= ev_last_d;
  end

  // Counter and reload stores: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[mem_waddr] <= cnt_wdata;
    if (rld_we) rld_mem[mem_waddr] <= new_cnt_q;
    rd_cnt_q <= cnt_mem[mem_raddr];
    rd_rld_q <= rld_mem[mem_raddr];
  end

  assign event_valid_o = ev_vld_q;
  assign event_kind_o  = ev_kind_q;
  assign event_slot_o  = SLOT_W'(ev_slot_q);
  assign last_event_o  = ev_last_q;

  `PTT_ASSERT_IMP(a_single_beat_last, clk_i, rst_ni, ev_vld_q && (ev_kind_q != EV_EXPIRED), ev_last_q, "create result without last mark")
  `PTT_ASSERT_IMP(a_proc_in_tick, clk_i, rst_ni, proc_vld_q, state_q == ST_TICK, "slot update outside a tick walk")
  `PTT_ASSERT_IMP(a_idle_clean, clk_i, rst_ni, state_q == ST_IDLE, !pend_vld_q && !proc_vld_q, "idle with a held expiry")
  `PTT_ASSERT_NXT(a_full_reported, clk_i, rst_ni, (state_q == ST_SCAN) && issue_done, ev_vld_q && (ev_kind_q == EV_FULL), "scan past table end without full result")

endmodule
